@@ rtl/olss_pkg.sv @@
`default_nettype none

package olss_pkg;

  // Fixed field widths of the request and response transactions
  localparam int unsigned OP_W     = 4;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Defaults for the top level parameters
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned WORD_WIDTH_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND       = 4'd0,
    OP_INSERT       = 4'd1,
    OP_REMOVE_AT    = 4'd2,
    OP_REMOVE_MATCH = 4'd3,
    OP_POP          = 4'd4,
    OP_TOP          = 4'd5,
    OP_GET          = 4'd6,
    OP_PUT          = 4'd7,
    OP_CLEAR        = 4'd8
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // What every cell does with its word in this cycle
  typedef enum logic [2:0] {
    CM_HOLD         = 3'd0,
    CM_INSERT       = 3'd1,
    CM_REMOVE_AT    = 3'd2,
    CM_REMOVE_MATCH = 3'd3,
    CM_WRITE        = 3'd4
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       rd_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/olss_req_if.sv @@
`default_nettype none

interface olss_req_if;
  logic                          valid;
  logic                          ready;
  logic [olss_pkg::OP_W-1:0]     operation;
  logic [olss_pkg::POS_W-1:0]    position;
  logic [olss_pkg::VAL_W-1:0]    value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/olss_rsp_if.sv @@
`default_nettype none

interface olss_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [olss_pkg::DATA_W-1:0]     data_out;
  logic [olss_pkg::STATUS_W-1:0]   status;
  logic [olss_pkg::COUNT_W-1:0]    entry_count;

  modport source (output valid, output data_out, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input data_out, input status, input entry_count,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/ordered_list_shift_store.sv @@
// Ordered list of up to DEPTH words held in a row of cells.
//
// Requests arrive on in_chan (operation, position, value) with a valid/ready
// handshake; every accepted transaction yields exactly one response on
// out_chan (data_out, status, entry_count) in the same order.
// Operations: append, insert, remove at, remove first match, pop, top, get,
// put and clear. A rejected request (full, out of range, empty, no match)
// leaves the list untouched. Unknown operation codes answer ok, data zero.
//
// Response: valid in the cycle after the request is accepted.
// Throughput: one request per cycle while out_chan.ready holds. All cells
// shift, compare and load in parallel in that cycle; the first-match flag
// and the read word ripple once through the cell row.
// Stall: the response sits in an output register; a new request is taken
// in the cycle the register is empty or drained by out_chan.ready.
// Reset (rst_n low, synchronous): the count goes to zero and no response is
// pending. Stored words are not cleared; an entry is only read after it
// was written.
`default_nettype none

module ordered_list_shift_store #(
  parameter int unsigned DEPTH      = olss_pkg::DEPTH_DEF,
  parameter int unsigned WORD_WIDTH = olss_pkg::WORD_WIDTH_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  olss_req_if.sink   in_chan,
  olss_rsp_if.source out_chan
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > olss_pkg::POS_W) ? CNT_W : olss_pkg::POS_W;

  logic [CNT_W-1:0]                  count_r;
  logic [CNT_W-1:0]                  count_nxt;
  logic                              out_valid_r;
  logic [olss_pkg::DATA_W-1:0]       out_data_r;
  olss_pkg::status_t                 out_status_r;
  logic [olss_pkg::COUNT_W-1:0]      out_count_r;

  logic                              accept;
  olss_pkg::op_t                     op;
  olss_pkg::status_t                 status_nxt;
  olss_pkg::cell_ctl_t               ctl_req;
  olss_pkg::cell_ctl_t               ctl;
  logic [CNT_W-1:0]                  tgt;
  logic [CNT_W-1:0]                  rd_idx;
  logic [WORD_WIDTH-1:0]             val_w;
  logic [CMP_W-1:0]                  pos_c;
  logic [CMP_W-1:0]                  cnt_c;
  logic                              full;
  logic                              empty;
  logic [olss_pkg::DATA_W-1:0]       data_nxt;

  logic [WORD_WIDTH-1:0]             words    [DEPTH];
  logic [WORD_WIDTH-1:0]             rd_chain [DEPTH+1];
  logic [DEPTH:0]                    found_chain;

  // Handshake: take a request whenever the response register can move
  assign in_chan.ready = ~out_valid_r | out_chan.ready;
  assign accept        = in_chan.valid & in_chan.ready;

  assign op    = olss_pkg::op_t'(in_chan.operation);
  assign val_w = WORD_WIDTH'(in_chan.value);
  assign pos_c = CMP_W'(in_chan.position);
  assign cnt_c = CMP_W'(count_r);
  assign full  = count_r == CNT_W'(DEPTH);
  assign empty = count_r == '0;

  // Decode the request against the current count
  always_comb begin
    status_nxt    = olss_pkg::ST_OK;
    ctl_req.mode  = olss_pkg::CM_HOLD;
    ctl_req.rd_en = 1'b0;
    tgt           = CNT_W'(in_chan.position);
    rd_idx        = CNT_W'(in_chan.position);
    count_nxt     = count_r;
    unique case (op)
      olss_pkg::OP_APPEND: begin
        if (full) status_nxt = olss_pkg::ST_FULL;
        else begin
          ctl_req.mode = olss_pkg::CM_WRITE;
          tgt          = count_r;
          count_nxt    = count_r + 1'b1;
        end
      end
      olss_pkg::OP_INSERT: begin
        if (full) status_nxt = olss_pkg::ST_FULL;
        else if (pos_c > cnt_c) status_nxt = olss_pkg::ST_RANGE;
        else begin
          ctl_req.mode = olss_pkg::CM_INSERT;
          count_nxt    = count_r + 1'b1;
        end
      end
      olss_pkg::OP_REMOVE_AT: begin
        if (empty) status_nxt = olss_pkg::ST_EMPTY;
        else if (pos_c >= cnt_c) status_nxt = olss_pkg::ST_RANGE;
        else begin
          ctl_req.mode = olss_pkg::CM_REMOVE_AT;
          count_nxt    = count_r - 1'b1;
        end
      end
      olss_pkg::OP_REMOVE_MATCH: begin
        if (!found_chain[DEPTH]) status_nxt = olss_pkg::ST_EMPTY;
        else begin
          ctl_req.mode = olss_pkg::CM_REMOVE_MATCH;
          count_nxt    = count_r - 1'b1;
        end
      end
      olss_pkg::OP_POP: begin
        if (empty) status_nxt = olss_pkg::ST_EMPTY;
        else begin
          ctl_req.rd_en = 1'b1;
          rd_idx        = count_r - 1'b1;
          count_nxt     = count_r - 1'b1;
        end
      end
      olss_pkg::OP_TOP: begin
        if (empty) status_nxt = olss_pkg::ST_EMPTY;
        else begin
          ctl_req.rd_en = 1'b1;
          rd_idx        = count_r - 1'b1;
        end
      end
      olss_pkg::OP_GET: begin
        if (empty) status_nxt = olss_pkg::ST_EMPTY;
        else if (pos_c >= cnt_c) status_nxt = olss_pkg::ST_RANGE;
        else ctl_req.rd_en = 1'b1;
      end
      olss_pkg::OP_PUT: begin
        if (empty) status_nxt = olss_pkg::ST_EMPTY;
        else if (pos_c >= cnt_c) status_nxt = olss_pkg::ST_RANGE;
        else ctl_req.mode = olss_pkg::CM_WRITE;
      end
      olss_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_nxt = olss_pkg::ST_OK;
      end
    endcase
  end

  // Cells change only on an accepted transaction
  always_comb begin
    ctl = ctl_req;
    if (!accept) ctl.mode = olss_pkg::CM_HOLD;
  end

  assign data_nxt = olss_pkg::DATA_W'(rd_chain[DEPTH]);

  // Row of cells: neighbors exchange words, match flag and read word ripple
  assign found_chain[0] = 1'b0;
  assign rd_chain[0]    = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_word;
    logic [WORD_WIDTH-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid_l
      assign left_word = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_mid_r
      assign right_word = words[i+1];
    end

    olss_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .tgt        (tgt),
      .rd_idx     (rd_idx),
      .value      (val_w),
      .left_word  (left_word),
      .right_word (right_word),
      .found_in   (found_chain[i]),
      .found_out  (found_chain[i+1]),
      .rd_in      (rd_chain[i]),
      .rd_out     (rd_chain[i+1]),
      .word       (words[i])
    );
  end

  // Advance the count on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // Response register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r   <= data_nxt;
      out_status_r <= status_nxt;
      out_count_r  <= olss_pkg::COUNT_W'(count_nxt);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.data_out    = out_data_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.entry_count = out_count_r;

  // Count never exceeds the list depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // A rejected request leaves the count alone
  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && status_nxt != olss_pkg::ST_OK |=> count_r == $past(count_r))
    else $error("rejected request changed the count");

  // The reported count is the stored count after the transaction
  a_count_report: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_count_r == olss_pkg::COUNT_W'(count_r))
    else $error("reported count differs from stored count");

  // Nonzero data only comes with an ok status
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    accept && data_nxt != '0 |-> status_nxt == olss_pkg::ST_OK)
    else $error("data returned on a failed request");

endmodule

`default_nettype wire

@@ rtl/olss_cell.sv @@
`default_nettype none

module olss_cell #(
  parameter int unsigned WORD_WIDTH = olss_pkg::WORD_WIDTH_DEF,
  parameter int unsigned CNT_W      = olss_pkg::COUNT_W,
  parameter int unsigned IDX        = 0
) (
  input  wire                     clk,
  input  olss_pkg::cell_ctl_t     ctl,
  input  wire [CNT_W-1:0]         count,
  input  wire [CNT_W-1:0]         tgt,
  input  wire [CNT_W-1:0]         rd_idx,
  input  wire [WORD_WIDTH-1:0]    value,
  input  wire [WORD_WIDTH-1:0]    left_word,
  input  wire [WORD_WIDTH-1:0]    right_word,
  input  wire                     found_in,
  output logic                    found_out,
  input  wire [WORD_WIDTH-1:0]    rd_in,
  output logic [WORD_WIDTH-1:0]   rd_out,
  output logic [WORD_WIDTH-1:0]   word
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [WORD_WIDTH-1:0] word_r;
  logic [WORD_WIDTH-1:0] word_nxt;
  logic                  occupied;
  logic                  rd_sel;

  assign word = word_r;

  // Compare against the search value; pass the first-match flag along
  assign occupied  = MY_IDX < count;
  assign found_out = found_in | (occupied & (word_r == value));

  // Merge this word into the read chain when addressed
  assign rd_sel = ctl.rd_en & (MY_IDX == rd_idx);
  assign rd_out = rd_in | (rd_sel ? word_r : '0);

  // Pick the next word: hold, take a neighbor, or load the value
  always_comb begin
    word_nxt = word_r;
    unique case (ctl.mode)
      olss_pkg::CM_HOLD: word_nxt = word_r;
      olss_pkg::CM_INSERT: begin
        if (MY_IDX > tgt) word_nxt = left_word;
        else if (MY_IDX == tgt) word_nxt = value;
      end
      olss_pkg::CM_REMOVE_AT: begin
        if (MY_IDX >= tgt) word_nxt = right_word;
      end
      olss_pkg::CM_REMOVE_MATCH: begin
        if (found_out) word_nxt = right_word;
      end
      olss_pkg::CM_WRITE: begin
        if (MY_IDX == tgt) word_nxt = value;
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

`default_nettype wire
